### rtl/bitmap_clear_run_finder_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap clear-run finder
// Concurrent check wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef BITMAP_CLEAR_RUN_FINDER_TOP_DEFINES_SVH
`define BITMAP_CLEAR_RUN_FINDER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define BCRF_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);
`define BCRF_ASSERT_IMPLIES(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);
`else
`define BCRF_ASSERT_ALWAYS(label, cond, msg)
`define BCRF_ASSERT_IMPLIES(label, pre, post, msg)
`endif

`endif

### rtl/bcrf_pkg.sv
// ----------------------------------------------------------------------------
// bcrf_pkg
// Shared types, codes and bit-scan helpers for the clear-run finder.
// ----------------------------------------------------------------------------
package bcrf_pkg;

   localparam int WORD_BITS     = 32;
   localparam int BIT_SEL_W     = 5;
   localparam int SIZE_W        = 14;
   localparam int FROM_W        = 16;
   localparam int IDX_W         = 8;
   localparam int MAP_WORDS_DEF = 256;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 14'd8192;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_FWD   = 2'd1;
   localparam logic [1:0] FUNC_BWD   = 2'd2;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_FWD   = 2'd1;
   localparam logic [1:0] CMD_BWD   = 2'd2;
   localparam logic [1:0] CMD_IMM   = 2'd3;

   typedef struct packed {
      logic [1:0]           kind;
      logic [IDX_W-1:0]     word_index;
      logic [WORD_BITS-1:0] word_data;
      logic [FROM_W-1:0]    from_index;
      logic [SIZE_W-1:0]    size;
   } cmd_type;

   typedef struct packed {
      logic [FROM_W-1:0] run_start;
      logic [SIZE_W-1:0] run_length;
   } rsp_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef struct packed {
      logic [SIZE_W-1:0] eff_size;
   } front_status_type;

   // mask with bits [k-1:0] set, k in 0..32
   function automatic logic [WORD_BITS-1:0] ones_below(input logic [5:0] k);
      logic [WORD_BITS-1:0] m;
      for (int b = 0; b < WORD_BITS; b++) begin
         m[b] = (6'(b) < k);
      end
      return m;
   endfunction

   // number of consecutive ones from bit 0 upward
   function automatic logic [5:0] trail_ones(input logic [WORD_BITS-1:0] v);
      logic [5:0] n;
      n = 6'd32;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!v[b]) n = 6'(b);
      end
      return n;
   endfunction

   // number of consecutive ones from bit 31 downward
   function automatic logic [5:0] lead_ones(input logic [WORD_BITS-1:0] v);
      logic [5:0] n;
      n = 6'd32;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (!v[b]) n = 6'(31 - b);
      end
      return n;
   endfunction

endpackage

### rtl/bcrf_fifo.sv
// ----------------------------------------------------------------------------
// bcrf_fifo
// Two-entry queue used between the front, the back and the result port.
// ----------------------------------------------------------------------------
module bcrf_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/bcrf_front.sv
// ----------------------------------------------------------------------------
// bcrf_front
// Size register and request classification into back-end commands.
// ----------------------------------------------------------------------------
module bcrf_front import bcrf_pkg::*; #(
   parameter int MAP_WORDS = MAP_WORDS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [1:0]           req_func,
   input  logic [IDX_W-1:0]     req_word_index,
   input  logic [WORD_BITS-1:0] req_word_data,
   input  logic [FROM_W-1:0]    req_from_index,
   input  logic                 csr_we,
   input  logic [SIZE_W-1:0]    csr_wdata,
   input  logic                 cmd_full,
   output logic                 cmd_push,
   output cmd_type              cmd,
   input  back_status_type      back_status,
   output front_status_type     front_status
);

   localparam int CAP = MAP_WORDS * WORD_BITS;

   logic [SIZE_W-1:0] size_ff;
   logic [SIZE_W-1:0] eff_size;
   logic              accept;
   logic              keep;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_we) begin
         size_ff <= csr_wdata;
      end
   end

   assign eff_size = (int'(size_ff) > CAP) ? SIZE_W'(CAP) : size_ff;
   assign front_status.eff_size = eff_size;

   assign req_full = cmd_full || back_status.clearing;
   assign accept   = req_push && !req_full;

   always_comb begin
      cmd.word_index = req_word_index;
      cmd.word_data  = req_word_data;
      cmd.from_index = req_from_index;
      cmd.size       = eff_size;
      cmd.kind       = CMD_IMM;
      keep           = 1'b0;
      unique case (req_func)
         FUNC_WRITE: begin
            cmd.kind = CMD_WRITE;
            keep     = (int'(req_word_index) < MAP_WORDS);
         end
         FUNC_FWD: begin
            keep     = 1'b1;
            cmd.kind = ({2'b00, eff_size} <= req_from_index) ? CMD_IMM : CMD_FWD;
         end
         FUNC_BWD: begin
            keep     = 1'b1;
            cmd.kind = ({2'b00, eff_size} <= req_from_index) ? CMD_IMM : CMD_BWD;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign cmd_push = accept && keep;

endmodule

### rtl/bcrf_back.sv
// ----------------------------------------------------------------------------
// bcrf_back
// Bitmap memory, reset clearing sweep and word-at-a-time run scanner.
// ----------------------------------------------------------------------------
module bcrf_back import bcrf_pkg::*; #(
   parameter int MAP_WORDS = MAP_WORDS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   input  logic            cmd_valid,
   output logic            cmd_pop,
   input  logic            rsp_full,
   output logic            rsp_push,
   output rsp_type         rsp_data,
   output back_status_type back_status
);

   localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int PW = (AW + 6 > 17) ? AW + 6 : 17;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [WORD_BITS-1:0] mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rdata_ff;

   logic [1:0]        state_ff, state_in;
   logic [AW-1:0]     cur_ff, cur_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              first_ff, first_in;
   logic              found_ff, found_in;
   logic              fwd_ff, fwd_in;
   logic [FROM_W-1:0] from_ff, from_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [FROM_W-1:0] start_ff, start_in;
   logic [SIZE_W:0]   len_ff, len_in;
   rsp_type           res_ff, res_in;

   logic                 mem_we;
   logic [AW-1:0]        waddr;
   logic [WORD_BITS-1:0] wdata;
   logic [AW-1:0]        raddr;
   logic [31:0]          widx_x, fword_x;

   // scan datapath
   logic [PW-1:0]        base, size_x;
   logic [WORD_BITS-1:0] lim, lo_mask, hi_mask, c, u;
   logic [5:0]           lo_i, hi_i, n, m, add;
   logic                 seek_none, last_word, done;
   logic [FROM_W-1:0]    scan_start;
   logic [SIZE_W:0]      scan_len;

   assign back_status.clearing = (state_ff == ST_CLEAR);
   assign widx_x  = 32'(cmd.word_index);
   assign fword_x = 32'(cmd.from_index[FROM_W-1:BIT_SEL_W]);

   always_comb begin
      base   = PW'(cur_ff) << BIT_SEL_W;
      size_x = PW'(size_ff);
      if (size_x >= base + PW'(WORD_BITS)) begin
         lim = '1;
      end else if (size_x <= base) begin
         lim = '0;
      end else begin
         lim = ones_below(6'(size_x - base));
      end
      lo_mask = first_ff ? ~ones_below({1'b0, from_ff[BIT_SEL_W-1:0]}) : '1;
      hi_mask = first_ff ? ones_below(6'({1'b0, from_ff[BIT_SEL_W-1:0]}) + 6'd1) : '1;

      c          = '0;
      u          = '0;
      lo_i       = 6'd0;
      hi_i       = 6'd31;
      n          = 6'd0;
      m          = 6'd0;
      add        = 6'd0;
      last_word  = 1'b0;
      scan_start = start_ff;
      if (fwd_ff) begin
         c         = ~rdata_ff & lim & lo_mask;
         lo_i      = found_ff ? 6'd0 : trail_ones(~c);
         seek_none = !found_ff && (c == '0);
         u         = c | ones_below(lo_i);
         n         = trail_ones(u);
         add       = n - lo_i;
         last_word = (base + PW'(WORD_BITS) >= size_x);
         done      = seek_none ? last_word : ((n != 6'd32) || last_word);
         if (!found_ff) begin
            scan_start = FROM_W'(base + PW'(lo_i));
         end
      end else begin
         c         = ~rdata_ff & hi_mask;
         // highest clear bit at or below the start point
         hi_i      = found_ff ? 6'd31 : (6'd31 - lead_ones(~c));
         seek_none = !found_ff && (c == '0);
         u         = c | ~ones_below(hi_i + 6'd1);
         m         = lead_ones(u);
         add       = m + hi_i - 6'd31;
         last_word = (cur_ff == '0);
         done      = seek_none ? last_word : ((m != 6'd32) || last_word);
         scan_start = FROM_W'(base + PW'(6'd32 - m));
      end
      scan_len = len_ff + (SIZE_W+1)'(add);
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      clr_in   = clr_ff;
      first_in = first_ff;
      found_in = found_ff;
      fwd_in   = fwd_ff;
      from_in  = from_ff;
      size_in  = size_ff;
      start_in = start_ff;
      len_in   = len_ff;
      res_in   = res_ff;
      mem_we   = 1'b0;
      waddr    = widx_x[AW-1:0];
      wdata    = cmd.word_data;
      raddr    = cur_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      rsp_data = res_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            waddr  = clr_ff;
            wdata  = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  CMD_WRITE: begin
                     mem_we  = 1'b1;
                     cmd_pop = 1'b1;
                  end
                  CMD_IMM: begin
                     if (!rsp_full) begin
                        rsp_push            = 1'b1;
                        rsp_data.run_start  = cmd.from_index;
                        rsp_data.run_length = '0;
                        cmd_pop             = 1'b1;
                     end
                  end
                  default: begin
                     cmd_pop  = 1'b1;
                     raddr    = fword_x[AW-1:0];
                     cur_in   = fword_x[AW-1:0];
                     first_in = 1'b1;
                     found_in = 1'b0;
                     len_in   = '0;
                     fwd_in   = (cmd.kind == CMD_FWD);
                     from_in  = cmd.from_index;
                     size_in  = cmd.size;
                     state_in = ST_SCAN;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            first_in = 1'b0;
            if (!seek_none) begin
               found_in = 1'b1;
               start_in = scan_start;
               len_in   = scan_len;
            end
            if (done) begin
               state_in = ST_DONE;
               if (seek_none) begin
                  res_in.run_start  = fwd_ff ? FROM_W'(size_ff) : '0;
                  res_in.run_length = '0;
               end else begin
                  res_in.run_start  = scan_start;
                  res_in.run_length = scan_len[SIZE_W-1:0];
               end
            end else begin
               cur_in = fwd_ff ? cur_ff + 1'b1 : cur_ff - 1'b1;
               raddr  = cur_in;
            end
         end
         ST_DONE: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      first_ff <= first_in;
      found_ff <= found_in;
      fwd_ff   <= fwd_in;
      from_ff  <= from_in;
      size_ff  <= size_in;
      start_ff <= start_in;
      len_ff   <= len_in;
      res_ff   <= res_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

### rtl/bitmap_clear_run_finder_top.sv
// ----------------------------------------------------------------------------
// bitmap_clear_run_finder_top
// Bitmap store with forward and backward clear-run search.
// ----------------------------------------------------------------------------
// Requests enter through a queue-style port: drive req_* and raise req_push;
// a request is taken on a clock edge where req_full is low. func 0 writes one
// 32-bit bitmap word, func 1 and 2 search for a clear run forward or
// backward from req_from_index. Writes and unused codes give no response.
// Responses leave in order through rsp_*: while rsp_empty is low the oldest
// response is shown, and rsp_pop takes it.
// A search reads one bitmap word per cycle; its result waits in the done
// state for room in the response queue, then the scanner goes idle for the
// next request. A write lands in memory when the idle scanner pops it from
// the request queue; an index at or past the size is answered from idle
// with a zero-length run and no scan. Requests are worked one at a time by
// the scanner; two-entry queues sit on both sides of it. csr_we/csr_wdata
// set the bitmap size; the user must write them only while idle, as the
// block does not enforce it. After reset the memory is swept to zero with
// req_full held high. If rsp_pop stays low the response queue fills, the
// scanner halts and the request queue fills in turn, raising req_full.
// ----------------------------------------------------------------------------
`include "bitmap_clear_run_finder_top_defines.svh"

module bitmap_clear_run_finder_top import bcrf_pkg::*; #(
   parameter int MAP_WORDS = MAP_WORDS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [1:0]           req_func,
   input  logic [IDX_W-1:0]     req_word_index,
   input  logic [WORD_BITS-1:0] req_word_data,
   input  logic [FROM_W-1:0]    req_from_index,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [FROM_W-1:0]    rsp_run_start,
   output logic [SIZE_W-1:0]    rsp_run_length,
   input  logic                 csr_we,
   input  logic [SIZE_W-1:0]    csr_wdata
);

   cmd_type          cmd_in, cmd_out;
   logic             cmd_push, cmd_pop, cmd_full, cmd_empty;
   rsp_type          rsp_in, rsp_out;
   logic             rsp_push, rsp_full;
   back_status_type  back_status;
   front_status_type front_status;

   bcrf_front #(.MAP_WORDS(MAP_WORDS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_func       (req_func),
      .req_word_index (req_word_index),
      .req_word_data  (req_word_data),
      .req_from_index (req_from_index),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .cmd_full       (cmd_full),
      .cmd_push       (cmd_push),
      .cmd            (cmd_in),
      .back_status    (back_status),
      .front_status   (front_status)
   );

   bcrf_fifo #(.WIDTH($bits(cmd_type))) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .full      (cmd_full),
      .empty     (cmd_empty)
   );

   bcrf_back #(.MAP_WORDS(MAP_WORDS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd_out),
      .cmd_valid   (!cmd_empty),
      .cmd_pop     (cmd_pop),
      .rsp_full    (rsp_full),
      .rsp_push    (rsp_push),
      .rsp_data    (rsp_in),
      .back_status (back_status)
   );

   bcrf_fifo #(.WIDTH($bits(rsp_type))) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .pop       (rsp_pop),
      .pop_data  (rsp_out),
      .full      (rsp_full),
      .empty     (rsp_empty)
   );

   assign rsp_run_start  = rsp_out.run_start;
   assign rsp_run_length = rsp_out.run_length;

   `BCRF_ASSERT_ALWAYS(a_full_while_clearing, !back_status.clearing || req_full, "request taken during clear sweep")
   `BCRF_ASSERT_IMPLIES(a_run_inside_size, !rsp_empty && (rsp_run_length != '0), (18'(rsp_run_start) + 18'(rsp_run_length)) <= 18'(front_status.eff_size), "run extends past bitmap size")
   `BCRF_ASSERT_IMPLIES(a_no_rsp_while_clearing, back_status.clearing, rsp_empty, "response present during clear sweep")

endmodule
